### design/vmt_pkg.sv
// Package for the 4x4 vector-matrix transform block.
// Holds the request action codes, the lane count and the stage-enable struct.
// No dependencies.
`timescale 1ns / 1ps

package vmt_pkg;

   // request action codes
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_XFORM = 1'b1;

   // vector length, matrix order and number of lanes
   localparam int LANES = 4;

   // per-stage load enables sent from the pipeline control to the lanes
   typedef struct packed {
      logic mul;   // product stage loads
      logic rnd;   // rounding stage loads
   } stage_en_type;

endpackage

### design/vmt_req_if.sv
// Request channel of the vector-matrix transform block: valid/ready plus payload.
// Depends on nothing; the word width is an interface parameter.
`timescale 1ns / 1ps

interface vmt_req_if #(
   parameter int WORD_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [1:0]            row_index;
   logic [WORD_WIDTH-1:0] elem_x;
   logic [WORD_WIDTH-1:0] elem_y;
   logic [WORD_WIDTH-1:0] elem_z;
   logic [WORD_WIDTH-1:0] elem_w;
   logic                  last_item;

   modport source (
      output valid, action, row_index, elem_x, elem_y, elem_z, elem_w, last_item,
      input  ready
   );
   modport sink (
      input  valid, action, row_index, elem_x, elem_y, elem_z, elem_w, last_item,
      output ready
   );
endinterface

### design/vmt_rsp_if.sv
// Result channel of the vector-matrix transform block: valid/ready plus payload.
// Depends on nothing; the word width is an interface parameter.
`timescale 1ns / 1ps

interface vmt_rsp_if #(
   parameter int WORD_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [WORD_WIDTH-1:0] out_x;
   logic [WORD_WIDTH-1:0] out_y;
   logic [WORD_WIDTH-1:0] out_z;
   logic [WORD_WIDTH-1:0] out_w;
   logic                  last_result;

   modport source (
      output valid, out_x, out_y, out_z, out_w, last_result,
      input  ready
   );
   modport sink (
      input  valid, out_x, out_y, out_z, out_w, last_result,
      output ready
   );
endinterface

### design/vector_matrix_transform_4x4.sv
// Top level of the 4x4 vector-matrix transform (signed fixed point, v times M).
// Depends on vmt_pkg, vmt_req_if, vmt_rsp_if, vmt_lane and vmt_merge.
//
//   channel | dir | payload                                          | handshake
//   req     | in  | action, row_index, elem_x..elem_w, last_item      | valid/ready
//   rsp     | out | out_x..out_w, last_result                         | valid/ready
//
// A transform request passes the product, rounding and merge registers, the first
// loaded at its accepting edge, before it shows up on rsp; one request per cycle
// is sustained while rsp takes every result.
// A load request writes its matrix row at the accepting edge and gives no result.
// Reset (synchronous) empties the pipeline and sets the matrix to the identity.
// A stall on rsp fills the empty pipeline slots first; req.ready drops only
// once every stage holds a request.
`timescale 1ns / 1ps

module vector_matrix_transform_4x4 import vmt_pkg::*; #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   vmt_req_if.sink   req,
   vmt_rsp_if.source rsp
);
   localparam int SUM_W = 2 * WORD_WIDTH - FRAC_BITS + 2;
   localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] DIAG =
      (FRAC_BITS >= WORD_WIDTH - 1) ? WORD_MAX : (WORD_WIDTH'(1) << FRAC_BITS);

   logic [LANES-1:0][LANES-1:0][WORD_WIDTH-1:0] matrix_ff;
   logic [LANES-1:0][WORD_WIDTH-1:0]            vec;
   logic [LANES-1:0][WORD_WIDTH-1:0]            col [LANES];
   logic [LANES-1:0][SUM_W-1:0]                 lane_sum;
   logic [LANES-1:0][WORD_WIDTH-1:0]            out_data;

   logic         accept;
   logic         load_req;
   logic         xform_req;
   logic         mul_valid_ff;
   logic         mul_last_ff;
   logic         rnd_valid_ff;
   logic         rnd_last_ff;
   logic         mul_free;
   logic         rnd_free;
   logic         out_free;
   stage_en_type stage_en;

   // request decode
   assign accept    = req.valid && req.ready;
   assign load_req  = accept && (req.action == ACTION_LOAD);
   assign xform_req = accept && (req.action == ACTION_XFORM);

   assign vec[0] = req.elem_x;
   assign vec[1] = req.elem_y;
   assign vec[2] = req.elem_z;
   assign vec[3] = req.elem_w;

   // a stage may load when empty or when its contents move on
   assign rnd_free     = !rnd_valid_ff || out_free;
   assign mul_free     = !mul_valid_ff || rnd_free;
   assign req.ready    = mul_free;
   assign stage_en.mul = mul_free;
   assign stage_en.rnd = rnd_free;

   // matrix store, identity after reset, one row written per load request
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < LANES; r++) begin
            for (int c = 0; c < LANES; c++) begin
               matrix_ff[r][c] <= (r == c) ? DIAG : '0;
            end
         end
      end else if (load_req) begin
         matrix_ff[req.row_index] <= vec;
      end
   end

   // pipeline valid and last flags
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         rnd_valid_ff <= 1'b0;
      end else begin
         if (mul_free) begin
            mul_valid_ff <= xform_req;
         end
         if (rnd_free) begin
            rnd_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_free) begin
         mul_last_ff <= req.last_item;
      end
      if (rnd_free) begin
         rnd_last_ff <= mul_last_ff;
      end
   end

   // one lane per output element, each fed one matrix column
   for (genvar j = 0; j < LANES; j++) begin : g_lane
      for (genvar k = 0; k < LANES; k++) begin : g_col
         assign col[j][k] = matrix_ff[k][j];
      end

      vmt_lane #(
         .WORD_WIDTH (WORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .stage_en (stage_en),
         .vec      (vec),
         .col      (col[j]),
         .sum      (lane_sum[j])
      );
   end

   vmt_merge #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rnd_valid_ff),
      .in_last   (rnd_last_ff),
      .lane_sum  (lane_sum),
      .out_free  (out_free),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_data),
      .out_last  (rsp.last_result)
   );

   assign rsp.out_x = out_data[0];
   assign rsp.out_y = out_data[1];
   assign rsp.out_z = out_data[2];
   assign rsp.out_w = out_data[3];

   // a load never enters the arithmetic pipeline
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      load_req |=> !mul_valid_ff)
      else $error("load request entered the product stage");

   // a transform always enters the product stage
   a_xform_enters: assert property (@(posedge clock) disable iff (reset)
      xform_req |=> mul_valid_ff)
      else $error("transform request lost at the product stage");

   // a rounded result with a free output register shows up as a result
   a_round_to_out: assert property (@(posedge clock) disable iff (reset)
      (rnd_valid_ff && out_free) |=> rsp.valid)
      else $error("rounded result not moved to the result register");

   // requests are refused only when every stage is occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (mul_valid_ff && rnd_valid_ff && rsp.valid && !rsp.ready))
      else $error("request refused with a free pipeline slot");

   // a loaded row holds the written x element in column 0
   a_row_written: assert property (@(posedge clock) disable iff (reset)
      load_req |=> (matrix_ff[$past(req.row_index)][0] == $past(req.elem_x)))
      else $error("matrix row not written by load request");

endmodule

### design/vmt_lane.sv
// One lane of the transform: computes one output element as the dot product of
// the vector with one matrix column. Multiply, round, then an unsaturated sum.
// Depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_lane import vmt_pkg::*; #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                      clock,
   input  stage_en_type                              stage_en,
   input  logic [LANES-1:0][WORD_WIDTH-1:0]          vec,
   input  logic [LANES-1:0][WORD_WIDTH-1:0]          col,
   output logic signed [2*WORD_WIDTH-FRAC_BITS+1:0]  sum
);
   localparam int PROD_W = 2 * WORD_WIDTH;
   localparam int RND_W  = PROD_W - FRAC_BITS;
   localparam int SUM_W  = RND_W + 2;
   localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

   logic signed [PROD_W-1:0] prod_in [LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic signed [RND_W-1:0]  rnd_in  [LANES];
   logic signed [RND_W-1:0]  rnd_ff  [LANES];
   logic [PROD_W-1:0]        biased  [LANES];

   // full-precision products, sign extended to double width
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         prod_in[k] = $signed(PROD_W'($signed(vec[k]))) * $signed(PROD_W'($signed(col[k])));
      end
   end

   // round to nearest: add half an LSB, drop the fraction bits (arithmetic)
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         biased[k] = prod_ff[k] + HALF;
         rnd_in[k] = $signed(biased[k][PROD_W-1:FRAC_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.mul) begin
         prod_ff <= prod_in;
      end
      if (stage_en.rnd) begin
         rnd_ff <= rnd_in;
      end
   end

   // sum of the rounded products, two guard bits, no saturation yet
   always_comb begin
      sum = '0;
      for (int k = 0; k < LANES; k++) begin
         sum = sum + SUM_W'(rnd_ff[k]);
      end
   end

endmodule

### design/vmt_merge.sv
// Merge stage: saturates the four lane sums to the word range, packs them with
// the last flag into the result register and runs the result handshake.
// Depends on vmt_pkg.
`timescale 1ns / 1ps

module vmt_merge import vmt_pkg::*; #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                in_valid,
   input  logic                                                in_last,
   input  logic [LANES-1:0][2*WORD_WIDTH-FRAC_BITS+1:0]        lane_sum,
   output logic                                                out_free,
   output logic                                                out_valid,
   input  logic                                                out_ready,
   output logic [LANES-1:0][WORD_WIDTH-1:0]                    out_data,
   output logic                                                out_last
);
   localparam int SUM_W = 2 * WORD_WIDTH - FRAC_BITS + 2;
   localparam int TOP_W = SUM_W - WORD_WIDTH + 1;
   localparam logic [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   logic                             valid_ff;
   logic                             valid_in;
   logic                             last_ff;
   logic [LANES-1:0][WORD_WIDTH-1:0] data_ff;
   logic [LANES-1:0][WORD_WIDTH-1:0] data_in;
   logic [TOP_W-1:0]                 top_bits [LANES];

   // result register is free when empty or being taken this cycle
   assign out_free = !valid_ff || out_ready;
   assign valid_in = out_free ? in_valid : valid_ff;

   // saturate: in range when the word's sign bit and all bits above it agree
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         top_bits[j] = lane_sum[j][SUM_W-1:WORD_WIDTH-1];
         if ((top_bits[j] == '0) || (top_bits[j] == '1)) begin
            data_in[j] = lane_sum[j][WORD_WIDTH-1:0];
         end else if (lane_sum[j][SUM_W-1]) begin
            data_in[j] = WORD_MIN;
         end else begin
            data_in[j] = WORD_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && in_valid) begin
         data_ff <= data_in;
         last_ff <= in_last;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;

endmodule

### tb/tb.sv
// Self-checking testbench for vector_matrix_transform_4x4: row loads and v * M transforms.
// Depends on vmt_pkg, vmt_req_if, vmt_rsp_if and the block itself; results are checked
// against an in-order Q16.16 prediction with random idling on both channels.
`timescale 1ns / 1ps

module tb import vmt_pkg::*; ();

   localparam int WORD_WIDTH    = 32;
   localparam int FRAC_BITS     = 16;
   localparam int IDLE_LIMIT    = 2000;
   localparam int LONG_HOLD     = 60;
   localparam int RANDOM_ITEMS  = 440;

   localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
   localparam logic [31:0] WORD_MIN = 32'h8000_0000;
   localparam logic [31:0] Q_ONE    = 32'h0001_0000;
   localparam logic [31:0] Q_HALF   = 32'h0000_8000;

   typedef struct packed {
      logic        action;
      logic [1:0]  row_index;
      logic [31:0] elem_x;
      logic [31:0] elem_y;
      logic [31:0] elem_z;
      logic [31:0] elem_w;
      logic        last_item;
   } request_type;

   typedef struct packed {
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic [31:0] out_w;
      logic        last_result;
   } vector_type;

   logic clock = 1'b0;
   logic reset;

   vmt_req_if #(.WORD_WIDTH(WORD_WIDTH)) req_ch ();
   vmt_rsp_if #(.WORD_WIDTH(WORD_WIDTH)) rsp_ch ();

   vector_matrix_transform_4x4 #(
      .WORD_WIDTH(WORD_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   always #4 clock = ~clock;

   // predicted matrix and the transformed vectors still in flight
   logic signed [31:0] model_matrix [LANES][LANES];
   vector_type         expected_vectors [$];

   int  error_count   = 0;
   int  items_sent    = 0;
   int  idle_cycles   = 0;
   bit  burst_mode    = 1'b0;
   int  hold_requests = 0;
   int  holds_served  = 0;
   int  hold_left     = 0;
   int  run_left      = 0;
   vector_type want;

   // ---------------------------------------------------------------- prediction

   function automatic logic [31:0] saturate_word(longint value);
      if (value > longint'(32'sh7fff_ffff))
         return WORD_MAX;
      if (value < -longint'(64'sd2147483648))
         return WORD_MIN;
      return value[31:0];
   endfunction

   function automatic vector_type transform_vector(request_type r);
      logic signed [31:0] v [LANES];
      logic [31:0]        lane_out [LANES];
      longint             acc;
      longint             prod;
      vector_type         res;
      v[0] = r.elem_x;
      v[1] = r.elem_y;
      v[2] = r.elem_z;
      v[3] = r.elem_w;
      for (int j = 0; j < LANES; j++) begin
         acc = 0;
         // each product rounded half-up on its own, then one saturation of the sum
         for (int k = 0; k < LANES; k++) begin
            prod = longint'(v[k]) * longint'(model_matrix[k][j]);
            acc += (prod + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
         end
         lane_out[j] = saturate_word(acc);
      end
      res.out_x       = lane_out[0];
      res.out_y       = lane_out[1];
      res.out_z       = lane_out[2];
      res.out_w       = lane_out[3];
      res.last_result = r.last_item;
      return res;
   endfunction

   function automatic void track_request(request_type r);
      if (r.action == ACTION_LOAD) begin
         model_matrix[r.row_index][0] = r.elem_x;
         model_matrix[r.row_index][1] = r.elem_y;
         model_matrix[r.row_index][2] = r.elem_z;
         model_matrix[r.row_index][3] = r.elem_w;
      end else begin
         expected_vectors.push_back(transform_vector(r));
      end
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // idle length: none in burst mode, else mostly none or short, now and then a long one
   function automatic int next_gap();
      int pick;
      if (burst_mode)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 4))
         1: return 32'($urandom_range(0, 32'h000f_ffff)) - 32'h0008_0000;
         2: return 32'($urandom_range(0, 32'h0001_ffff)) - 32'h0001_0000;
         3: begin
            case ($urandom_range(0, 5))
               0: return WORD_MAX;
               1: return WORD_MIN;
               2: return Q_ONE;
               3: return -Q_ONE;
               4: return 32'hffff_ffff;
               default: return 32'h0;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic request_type make_request(logic action, logic [1:0] row,
                                                logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [31:0] w,
                                                logic last);
      request_type r;
      r.action    = action;
      r.row_index = row;
      r.elem_x    = x;
      r.elem_y    = y;
      r.elem_z    = z;
      r.elem_w    = w;
      r.last_item = last;
      return r;
   endfunction

   // Offer one request and hold it until accepted; valid is left high for back-to-back use.
   task automatic send_request(request_type r);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= r.action;
      req_ch.row_index <= r.row_index;
      req_ch.elem_x    <= r.elem_x;
      req_ch.elem_y    <= r.elem_y;
      req_ch.elem_z    <= r.elem_z;
      req_ch.elem_w    <= r.elem_w;
      req_ch.last_item <= r.last_item;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      track_request(r);
      items_sent++;
   endtask

   task automatic release_request();
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_for_results();
      release_request();
      do @(posedge clock); while (expected_vectors.size() != 0);
   endtask

   task automatic load_random_matrix();
      for (int row = 0; row < LANES; row++)
         send_request(make_request(ACTION_LOAD, row[1:0], random_word(), random_word(),
                                   random_word(), random_word(), 1'($urandom_range(0, 1))));
   endtask

   // a batch of vectors with last on the final one; 3-vectors carry w = 1.0
   task automatic send_batch(int count, bit three_vector);
      for (int n = 0; n < count; n++)
         send_request(make_request(ACTION_XFORM, 2'($urandom_range(0, 3)), random_word(),
                                   random_word(), random_word(),
                                   three_vector ? Q_ONE : random_word(), n == count - 1));
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_identity_reset();
      send_request(make_request(ACTION_XFORM, 2'd0, WORD_MAX, WORD_MIN, 32'h0, 32'hffff_ffff,
                                1'b0));
      send_request(make_request(ACTION_XFORM, 2'd3, WORD_MIN, WORD_MAX, Q_ONE, -Q_ONE, 1'b1));
      send_request(make_request(ACTION_XFORM, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
   endtask

   task automatic test_extremes_and_saturation();
      // last flag on a row load must be ignored
      send_request(make_request(ACTION_LOAD, 2'd0, WORD_MAX, WORD_MIN, Q_ONE, 32'h0, 1'b1));
      send_request(make_request(ACTION_LOAD, 2'd1, WORD_MAX, WORD_MIN, -Q_ONE, Q_HALF, 1'b0));
      send_request(make_request(ACTION_LOAD, 2'd2, 32'h0, 32'h1, Q_ONE, 32'hffff_ffff, 1'b1));
      send_request(make_request(ACTION_LOAD, 2'd3, 32'hffff_ffff, 32'h0, 32'h1, Q_ONE, 1'b0));
      // positive overflow on x, negative on y, then the reverse
      send_request(make_request(ACTION_XFORM, 2'd0, WORD_MAX, WORD_MAX, 32'h0, 32'h0, 1'b0));
      send_request(make_request(ACTION_XFORM, 2'd0, WORD_MIN, WORD_MIN, 32'h0, 32'h0, 1'b1));
      send_request(make_request(ACTION_XFORM, 2'd2, WORD_MAX, WORD_MIN, Q_ONE, -Q_ONE, 1'b0));
      send_request(make_request(ACTION_XFORM, 2'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
   endtask

   task automatic test_rounding_ties();
      // row 0 of +0.5, +1.5, -0.5, -1.5 times one ulp: exact halves round up
      send_request(make_request(ACTION_LOAD, 2'd0, Q_HALF, 32'h0001_8000, -Q_HALF,
                                -32'h0001_8000, 1'b0));
      send_request(make_request(ACTION_XFORM, 2'd0, 32'h1, 32'h0, 32'h0, 32'h0, 1'b0));
      send_request(make_request(ACTION_XFORM, 2'd0, 32'hffff_ffff, 32'h0, 32'h0, 32'h0, 1'b1));
      send_request(make_request(ACTION_XFORM, 2'd0, 32'h3, 32'h0, 32'h0, 32'h0, 1'b0));
   endtask

   task automatic test_matrix_product();
      load_random_matrix();
      send_batch(LANES, 1'b0);
      send_batch(6, 1'b1);
   endtask

   task automatic test_back_to_back();
      burst_mode = 1'b1;
      load_random_matrix();
      send_batch(30, 1'b0);
      wait_for_results();
      burst_mode = 1'b0;
   endtask

   task automatic test_output_stall();
      // long receiver hold while requests keep coming, so the pipeline backs up
      hold_requests++;
      send_batch(20, 1'b0);
      // sender pauses until everything has come back
      wait_for_results();
      send_batch(5, 1'b1);
   endtask

   task automatic test_random_stream();
      int start;
      int pick;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            load_random_matrix();
            send_batch($urandom_range(1, 12), $urandom_range(0, 1));
         end else if (pick == 7) begin
            send_request(make_request(ACTION_LOAD, 2'($urandom_range(0, 3)), random_word(),
                                      random_word(), random_word(), random_word(),
                                      1'($urandom_range(0, 1))));
         end else begin
            send_request(make_request(ACTION_XFORM, 2'($urandom_range(0, 3)), random_word(),
                                      random_word(), random_word(), random_word(),
                                      1'($urandom_range(0, 1))));
         end
      end
   endtask

   // ---------------------------------------------------------------- result checking

   task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %h, got %h", name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_vectors.size() == 0) begin
            $error("result with no transform request outstanding");
            error_count++;
         end else begin
            want = expected_vectors.pop_front();
            check_field("out_x", want.out_x, rsp_ch.out_x);
            check_field("out_y", want.out_y, rsp_ch.out_y);
            check_field("out_z", want.out_z, rsp_ch.out_z);
            check_field("out_w", want.out_w, rsp_ch.out_w);
            check_field("last_result", 32'(want.last_result), 32'(rsp_ch.last_result));
         end
      end

      // receiver readiness: long hold on request, else random stalls and runs
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (burst_mode || run_left > 0) begin
         if (run_left > 0)
            run_left--;
         rsp_ch.ready <= 1'b1;
      end else begin
         hold_left = next_gap();
         if (hold_left == 0) begin
            run_left = $urandom_range(0, 6);
            rsp_ch.ready <= 1'b1;
         end else begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- watchdog

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.action    = ACTION_LOAD;
      req_ch.row_index = 2'd0;
      req_ch.elem_x    = 32'h0;
      req_ch.elem_y    = 32'h0;
      req_ch.elem_z    = 32'h0;
      req_ch.elem_w    = 32'h0;
      req_ch.last_item = 1'b0;
      for (int k = 0; k < LANES; k++)
         for (int j = 0; j < LANES; j++)
            model_matrix[k][j] = (k == j) ? Q_ONE : 32'h0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_identity_reset();
      test_extremes_and_saturation();
      test_rounding_ties();
      test_matrix_product();
      test_back_to_back();
      test_output_stall();
      test_random_stream();

      wait_for_results();
      repeat (10) @(posedge clock);
      if (expected_vectors.size() != 0) begin
         $error("%0d transformed vectors never arrived", expected_vectors.size());
         error_count++;
      end

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sim.f
design/vmt_pkg.sv
design/vmt_req_if.sv
design/vmt_rsp_if.sv
design/vmt_lane.sv
design/vmt_merge.sv
design/vector_matrix_transform_4x4.sv
tb/tb.sv
